>>> hdl/dstq_pkg.sv
`default_nettype none

package dstq_pkg;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_EXPIRED  = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  task_kind;
    logic [31:0] peer_addr;
    logic [31:0] file_ident;
    logic [31:0] fragment_ident;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // take the input item
    logic full_reply;  // insert rejected
    logic scan;        // move the insert scan on to the next entry
    logic put;         // write new entry at the slot, reply stored
    logic step;        // move previous entry up into the slot
    logic pop;         // emit head as expired and drop it
    logic finish;      // closing item of a poll
  } dstq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_last;   // one entry left to examine in the insert walk
    logic new_later;   // new deadline strictly after the entry read
    logic head_due;    // head deadline at or before the poll time
  } dstq_status_t;

  // a strictly after b, modulo 2^32
  function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

`default_nettype wire

>>> hdl/dstq_ctrl.sv
`default_nettype none

module dstq_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire                   opcode,
  input  dstq_pkg::dstq_status_t status,
  output dstq_pkg::dstq_cmd_t    cmd,
  output logic                  busy
);
  import dstq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_WALK,
    S_INS_PUT,
    S_POLL_WALK
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (opcode == OP_INSERT) begin
            if (status.full) begin
              cmd.full_reply = 1'b1;
            end else if (status.empty) begin
              state_next = S_INS_PUT;
            end else begin
              state_next = S_INS_SCAN;
            end
          end else begin
            if (status.empty) begin
              cmd.finish = 1'b1;
            end else begin
              state_next = S_POLL_WALK;
            end
          end
        end
      end
      // scan from the head for the first entry not earlier than the new one
      S_INS_SCAN: begin
        if (status.new_later) begin
          if (status.walk_last) begin
            cmd.put    = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.scan = 1'b1;
          end
        end else begin
          state_next = S_INS_WALK;
        end
      end
      // shift the remaining entries up one place, from the tail down
      S_INS_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_last) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_IDLE;
      end
      S_POLL_WALK: begin
        if (!status.empty && status.head_due) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dstq_datapath.sv
`default_nettype none

module dstq_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  dstq_pkg::dstq_cmd_t     cmd,
  output dstq_pkg::dstq_status_t  status,
  input  wire                    opcode,
  input  wire  [31:0]            now_ms,
  input  wire  [30:0]            delay_ms,
  input  wire  [7:0]             task_kind,
  input  wire  [31:0]            peer_addr,
  input  wire  [31:0]            file_ident,
  input  wire  [31:0]            fragment_ident,
  output logic                   result_strobe,
  output logic [1:0]             item_kind,
  output logic                   status_out,
  output logic [7:0]             task_kind_out,
  output logic [31:0]            peer_addr_out,
  output logic [31:0]            file_ident_out,
  output logic [31:0]            fragment_ident_out,
  output logic                   timer_armed,
  output logic [30:0]            next_delay_ms,
  output logic                   last
);
  import dstq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == IW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? IW'(QUEUE_DEPTH - 1) : x - 1'b1;
  endfunction

  // circular buffer, head is the earliest deadline
  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] slot;
  logic [IW-1:0] slot_next;
  logic [IW-1:0] probe;
  logic [IW-1:0] probe_next;
  logic [CW-1:0] kleft;
  logic          poll_mode;
  logic          cap_op;
  logic [31:0]   cap_now;
  entry_t        cap_entry;

  logic [CW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic [IW-1:0] rd_addr;
  logic [31:0]   head_diff;

  assign tail_sum = (CW+1)'(head) + (CW+1)'(count);
  assign tail = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                IW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    slot_next  = slot;
    probe_next = probe;
    if (cmd.pop) begin
      head_next  = idx_inc(head);
      count_next = count - 1'b1;
    end
    if (cmd.put) begin
      count_next = count + 1'b1;
    end
    if (cmd.capture) begin
      slot_next  = tail;
      probe_next = head;
    end else if (cmd.step) begin
      slot_next = idx_dec(slot);
    end else if (cmd.scan) begin
      probe_next = idx_inc(probe);
    end
  end

  // insert reads forward from the head while scanning, then backward from the tail
  assign poll_mode = cmd.capture ? (opcode == OP_POLL) : (cap_op == OP_POLL);
  assign rd_addr   = poll_mode ? head_next :
                     ((cmd.capture || cmd.scan) ? probe_next : idx_dec(slot_next));
  assign head_diff = rd_data.deadline - cap_now;

  assign status.full      = (count == CW'(QUEUE_DEPTH));
  assign status.empty     = (count == '0);
  assign status.walk_last = (kleft == CW'(1));
  assign status.new_later = later_than(cap_entry.deadline, rd_data.deadline);
  assign status.head_due  = !later_than(rd_data.deadline, cap_now);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.put) begin
      mem[slot] <= cap_entry;
    end else if (cmd.step) begin
      mem[slot] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
    slot  <= slot_next;
    probe <= probe_next;
    if (cmd.capture) begin
      kleft                    <= count;
      cap_op                   <= opcode;
      cap_now                  <= now_ms;
      cap_entry.deadline       <= now_ms + {1'b0, delay_ms};
      cap_entry.task_kind      <= task_kind;
      cap_entry.peer_addr      <= peer_addr;
      cap_entry.file_ident     <= file_ident;
      cap_entry.fragment_ident <= fragment_ident;
    end else if (cmd.step || cmd.scan) begin
      kleft <= kleft - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.full_reply | cmd.put | cmd.pop | cmd.finish;
    end
    item_kind          <= KIND_INSERT;
    status_out         <= STATUS_STORED;
    task_kind_out      <= '0;
    peer_addr_out      <= '0;
    file_ident_out     <= '0;
    fragment_ident_out <= '0;
    timer_armed        <= 1'b0;
    next_delay_ms      <= '0;
    last               <= 1'b1;
    if (cmd.full_reply) begin
      status_out <= STATUS_FULL;
    end else if (cmd.pop) begin
      item_kind          <= KIND_EXPIRED;
      task_kind_out      <= rd_data.task_kind;
      peer_addr_out      <= rd_data.peer_addr;
      file_ident_out     <= rd_data.file_ident;
      fragment_ident_out <= rd_data.fragment_ident;
      last               <= 1'b0;
    end else if (cmd.finish) begin
      item_kind <= KIND_FINISHED;
      if (!status.empty) begin
        timer_armed   <= 1'b1;
        next_delay_ms <= head_diff[30:0];
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.full_reply, cmd.scan, cmd.put, cmd.step, cmd.pop, cmd.finish}))
    else $error("more than one datapath action in a cycle");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (count != CW'(QUEUE_DEPTH)))
    else $error("entry written into a full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0) ##1 (count == $past(count) - 1'b1))
    else $error("pop did not drop exactly one entry");

endmodule

`default_nettype wire

>>> hdl/deadline_sorted_timer_queue_core.sv
`default_nettype none

// Insert: on an empty queue the new entry is written directly; otherwise a scan from the head
// to the slot, then a shift of the later entries. A full queue is answered with a full reply.
// Poll: one expired item per cycle, then the closing item (only the closing item if empty).
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous reset empties the queue; entry storage is not cleared.
module deadline_sorted_timer_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         opcode,
  input  wire  [31:0] now_ms,
  input  wire  [30:0] delay_ms,
  input  wire  [7:0]  task_kind,
  input  wire  [31:0] peer_addr,
  input  wire  [31:0] file_ident,
  input  wire  [31:0] fragment_ident,
  output logic        result_strobe,
  output logic [1:0]  item_kind,
  output logic        status,
  output logic [7:0]  task_kind_out,
  output logic [31:0] peer_addr_out,
  output logic [31:0] file_ident_out,
  output logic [31:0] fragment_ident_out,
  output logic        timer_armed,
  output logic [30:0] next_delay_ms,
  output logic        last
);
  import dstq_pkg::*;

  dstq_cmd_t    cmd;
  dstq_status_t dp_status;

  dstq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (dp_status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dstq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (dp_status),
    .opcode             (opcode),
    .now_ms             (now_ms),
    .delay_ms           (delay_ms),
    .task_kind          (task_kind),
    .peer_addr          (peer_addr),
    .file_ident         (file_ident),
    .fragment_ident     (fragment_ident),
    .result_strobe      (result_strobe),
    .item_kind          (item_kind),
    .status_out         (status),
    .task_kind_out      (task_kind_out),
    .peer_addr_out      (peer_addr_out),
    .file_ident_out     (file_ident_out),
    .fragment_ident_out (fragment_ident_out),
    .timer_armed        (timer_armed),
    .next_delay_ms      (next_delay_ms),
    .last               (last)
  );

endmodule

`default_nettype wire

>>> test/deadline_sorted_timer_queue_core_test.sv
`timescale 1ns / 1ps

module deadline_sorted_timer_queue_core_test;
  import dstq_pkg::*;

  localparam int QUEUE_DEPTH   = 32;
  localparam int ITEM_TARGET   = 460;
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

  typedef struct {
    logic [1:0]  kind;
    logic        status;
    logic [7:0]  task_kind;
    logic [31:0] peer_addr;
    logic [31:0] file_ident;
    logic [31:0] fragment_ident;
    logic        armed;
    logic [30:0] next_delay;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        opcode = OP_INSERT;
  logic [31:0] now_ms = '0;
  logic [30:0] delay_ms = '0;
  logic [7:0]  task_kind = '0;
  logic [31:0] peer_addr = '0;
  logic [31:0] file_ident = '0;
  logic [31:0] fragment_ident = '0;

  logic        busy;
  logic        result_strobe;
  logic [1:0]  item_kind;
  logic        status;
  logic [7:0]  task_kind_out;
  logic [31:0] peer_addr_out;
  logic [31:0] file_ident_out;
  logic [31:0] fragment_ident_out;
  logic        timer_armed;
  logic [30:0] next_delay_ms;
  logic        last;

  // shadow copy of the pending timers, head at index 0
  entry_t        shadow_queue [QUEUE_DEPTH];
  int            pending_timers = 0;
  timer_result_t expected_results [$];

  int          error_count = 0;
  int          accepted_items = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  logic [31:0] clock_ms;

  deadline_sorted_timer_queue_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a strictly later than b, modulo 2^32
  function automatic bit deadline_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 32'd0) && !diff[31];
  endfunction

  function automatic void push_result(logic [1:0] kind, logic stat, entry_t e, logic armed,
                                      logic [30:0] delay, logic fin);
    timer_result_t r;
    r.kind           = kind;
    r.status         = stat;
    r.task_kind      = e.task_kind;
    r.peer_addr      = e.peer_addr;
    r.file_ident     = e.file_ident;
    r.fragment_ident = e.fragment_ident;
    r.armed          = armed;
    r.next_delay     = delay;
    r.last           = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_timer_op(logic op, logic [31:0] now, logic [30:0] delay,
                                           logic [7:0] kind, logic [31:0] peer,
                                           logic [31:0] file, logic [31:0] frag);
    entry_t      fresh;
    entry_t      blank;
    logic [31:0] head_gap;
    int          pos;
    blank = '0;
    if (op == OP_INSERT) begin
      if (pending_timers == QUEUE_DEPTH) begin
        push_result(KIND_INSERT, STATUS_FULL, blank, 1'b0, '0, 1'b1);
        return;
      end
      fresh = '{deadline: now + {1'b0, delay}, task_kind: kind, peer_addr: peer,
                file_ident: file, fragment_ident: frag};
      // new entry goes ahead of any equal deadline
      pos = 0;
      while (pos < pending_timers &&
             deadline_after(fresh.deadline, shadow_queue[pos].deadline))
        pos++;
      for (int i = pending_timers; i > pos; i--)
        shadow_queue[i] = shadow_queue[i - 1];
      shadow_queue[pos] = fresh;
      pending_timers++;
      push_result(KIND_INSERT, STATUS_STORED, blank, 1'b0, '0, 1'b1);
    end else begin
      // only the head is examined
      while (pending_timers > 0 && !deadline_after(shadow_queue[0].deadline, now)) begin
        push_result(KIND_EXPIRED, STATUS_STORED, shadow_queue[0], 1'b0, '0, 1'b0);
        for (int i = 1; i < pending_timers; i++)
          shadow_queue[i - 1] = shadow_queue[i];
        pending_timers--;
      end
      if (pending_timers > 0) begin
        head_gap = shadow_queue[0].deadline - now;
        push_result(KIND_FINISHED, STATUS_STORED, blank, 1'b1, head_gap[30:0], 1'b1);
      end else begin
        push_result(KIND_FINISHED, STATUS_STORED, blank, 1'b0, '0, 1'b1);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (!rst && result_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no transfer pending: item_kind %0d", item_kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_kind", want.kind, item_kind);
        check_field("status", want.status, status);
        check_field("task_kind_out", want.task_kind, task_kind_out);
        check_field("peer_addr_out", want.peer_addr, peer_addr_out);
        check_field("file_ident_out", want.file_ident, file_ident_out);
        check_field("fragment_ident_out", want.fragment_ident, fragment_ident_out);
        check_field("timer_armed", want.armed, timer_armed);
        check_field("next_delay_ms", want.next_delay, next_delay_ms);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high after a transfer; whoever goes idle next drops it
  task automatic send_item(input logic op, input logic [31:0] now, input logic [30:0] delay,
                           input logic [7:0] kind, input logic [31:0] peer,
                           input logic [31:0] file, input logic [31:0] frag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    opcode         <= op;
    now_ms         <= now;
    delay_ms       <= delay;
    task_kind      <= kind;
    peer_addr      <= peer;
    file_ident     <= file;
    fragment_ident <= frag;
    @(posedge clk);
    while (busy) @(posedge clk);
    accepted_items++;
    predict_timer_op(op, now, delay, kind, peer, file, frag);
  endtask

  task automatic insert_at(input logic [31:0] now, input logic [30:0] delay);
    send_item(OP_INSERT, now, delay, 8'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic poll_at(input logic [31:0] now);
    send_item(OP_POLL, now, 31'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_poll();
    poll_at(32'h0000_0000);
    poll_at(32'hFFFF_FFFF);
  endtask

  task automatic test_field_extremes();
    send_item(OP_INSERT, 32'h0, 31'h0, 8'hFF, '1, '1, '1);
    send_item(OP_INSERT, 32'h0, 31'h7FFF_FFFF, 8'h00, '0, '0, '0);
    poll_at(32'h0);             // first due, second armed at the largest delay
    poll_at(32'h7FFF_FFFF);
    insert_at(32'hFFFF_FFFF, 31'd1);   // deadline wraps to zero
    poll_at(32'hFFFF_FFFF);
    poll_at(32'h0);
  endtask

  task automatic test_equal_deadlines();
    insert_at(32'd1000, 31'd500);
    insert_at(32'd1500, 31'd700);
    insert_at(32'd1200, 31'd300);
    insert_at(32'd1500, 31'd0);
    poll_at(32'd1499);
    poll_at(32'd1500);          // equal deadlines come out newest first
    poll_at(32'd2200);
  endtask

  task automatic test_due_behind_later_head();
    insert_at(32'h0, 31'd100);
    insert_at(32'h0, 31'h7000_0000);
    poll_at(32'hA000_0000);     // head reads as later, the entry behind it is due
    poll_at(32'd100);
    poll_at(32'h7000_0000);
  endtask

  task automatic test_full_queue();
    no_idle = 1'b1;
    repeat (QUEUE_DEPTH) insert_at(32'd5000, 31'($urandom_range(0, 1000)));
    no_idle = 1'b0;
    insert_at(32'd5000, 31'd10);
    poll_at(32'd6000);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int mode;
    int burst;
    clock_ms = $urandom;
    while (accepted_items < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          clock_ms += $urandom_range(0, 40);
          insert_at(clock_ms, 31'($urandom_range(0, 2500)));
        end
        clock_ms += $urandom_range(0, 1500);
        poll_at(clock_ms);
      end else if (mode < 14) begin
        burst = $urandom_range(24, 40);
        repeat (burst) insert_at(clock_ms, 31'($urandom_range(0, 800)));
        clock_ms += $urandom_range(0, 900);
        poll_at(clock_ms);
      end else if (mode < 16) begin
        // far deadlines and big jumps of the clock
        insert_at(clock_ms, 31'($urandom));
        clock_ms += $urandom;
        poll_at(clock_ms);
      end else if (mode < 19) begin
        send_item(1'($urandom_range(0, 1)), $urandom, 31'($urandom), 8'($urandom),
                  $urandom, $urandom, $urandom);
      end else begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_poll();
    test_field_extremes();
    test_equal_deadlines();
    test_due_behind_later_head();
    test_full_queue();
    test_random_traffic();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dstq_pkg.sv
hdl/dstq_ctrl.sv
hdl/dstq_datapath.sv
hdl/deadline_sorted_timer_queue_core.sv
test/deadline_sorted_timer_queue_core_test.sv
